### hw/rtl/e2d_pkg.sv
package e2d_pkg;

  localparam int unsigned MANT_W = 64;
  localparam int unsigned LZ_W   = 6;
  localparam int unsigned X_W    = 17;
  localparam int unsigned K_W    = 7;

  localparam logic [14:0] EXT_EXP_MAX   = 15'h7FFF;
  localparam logic [62:0] DBL_INF_MAG   = 63'h7FF0_0000_0000_0000;
  // x = p + e - 16383 - 63
  localparam logic signed [X_W-1:0] X_OFFSET  = 17'sd16446;
  localparam logic signed [X_W-1:0] X_MAX     = 17'sd1023;
  localparam logic signed [X_W-1:0] X_MIN     = -17'sd1022;
  localparam logic signed [X_W-1:0] EXP_BIAS1 = 17'sd1022;
  localparam logic signed [X_W-1:0] DEN_LIMIT = 17'sd53;
  localparam logic [K_W-1:0] K_NORMAL = 7'd11;
  localparam logic [K_W-1:0] K_FLUSH  = 7'd65;

  // after exponent and leading-one stage
  typedef struct packed {
    logic                    sign;
    logic                    special;
    logic                    zero;
    logic [LZ_W-1:0]         lz;
    logic signed [X_W-1:0]   x;
    logic [MANT_W-1:0]       m;
  } lead_t;

  // after normalization stage
  typedef struct packed {
    logic               sign;
    logic               special;
    logic               zero;
    logic               ovf;
    logic [K_W-1:0]     k;
    logic [10:0]        expf;
    logic [MANT_W-1:0]  mn;
  } norm_t;

endpackage

### hw/rtl/e2d_if.sv
interface e2d_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] sign_and_exponent;
  logic [63:0] mantissa;

  modport source (output valid, output sign_and_exponent, output mantissa, input ready);
  modport sink   (input valid, input sign_and_exponent, input mantissa, output ready);
endinterface

interface e2d_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] double_bits;
  logic        was_special;

  modport source (output valid, output double_bits, output was_special, input ready);
  modport sink   (input valid, input double_bits, input was_special, output ready);
endinterface

### hw/rtl/e2d_lead.sv
module e2d_lead (
  input  logic [15:0]    se,
  input  logic [63:0]    m,
  output e2d_pkg::lead_t res
);

  logic [5:0] p;

  // leading-one position
  always_comb begin
    p = '0;
    for (int i = 0; i < 64; i++) begin
      if (m[i]) p = 6'(i);
    end
  end

  always_comb begin
    res.sign    = se[15];
    res.special = (se[14:0] == e2d_pkg::EXT_EXP_MAX);
    res.zero    = (m == '0);
    res.lz      = 6'(6'd63 - p);
    res.x       = $signed({11'b0, p}) + $signed({2'b0, se[14:0]}) - e2d_pkg::X_OFFSET;
    res.m       = m;
  end

endmodule

### hw/rtl/e2d_norm.sv
module e2d_norm (
  input  e2d_pkg::lead_t lead,
  output e2d_pkg::norm_t res
);

  logic signed [16:0] d;
  logic signed [16:0] ebias;

  always_comb begin
    d     = e2d_pkg::X_MIN - lead.x;
    ebias = lead.x + e2d_pkg::EXP_BIAS1;
    res.sign    = lead.sign;
    res.special = lead.special;
    res.zero    = lead.zero;
    res.ovf     = (lead.x > e2d_pkg::X_MAX);
    res.mn      = lead.m << lead.lz;
    // denormal range adds right shift beyond the 11 dropped bits
    if (lead.x < e2d_pkg::X_MIN) begin
      res.expf = '0;
      if (d > e2d_pkg::DEN_LIMIT) res.k = e2d_pkg::K_FLUSH;
      else                        res.k = 7'(e2d_pkg::K_NORMAL + 7'(d[6:0]));
    end else begin
      res.expf = ebias[10:0];
      res.k    = e2d_pkg::K_NORMAL;
    end
  end

endmodule

### hw/rtl/e2d_round.sv
module e2d_round (
  input  e2d_pkg::norm_t nrm,
  output logic [63:0]    double_bits,
  output logic           was_special
);

  logic [127:0] wide;
  logic [53:0]  q;
  logic         up;
  logic [63:0]  bits;
  logic [62:0]  mag;

  // shift, round to nearest even, assemble
  always_comb begin
    wide = {nrm.mn, 64'b0} >> nrm.k;
    up   = wide[63] && ((|wide[62:0]) || wide[64]);
    q    = {1'b0, wide[116:64]} + {53'b0, up};
    bits = {1'b0, nrm.expf, 52'b0} + {10'b0, q};
    // zero mantissa wins over any exponent overflow
    if (nrm.special)                                          mag = e2d_pkg::DBL_INF_MAG;
    else if (nrm.zero)                                        mag = '0;
    else if (nrm.ovf || bits[62:0] >= e2d_pkg::DBL_INF_MAG)   mag = e2d_pkg::DBL_INF_MAG;
    else                                                      mag = bits[62:0];
    double_bits = {nrm.sign, mag};
    was_special = nrm.special;
  end

endmodule

### hw/rtl/extended80_to_double_converter_top.sv
// 80-bit extended to IEEE binary64 converter.
// in_ch carries an item of sign_and_exponent (sign in bit 15, biased
// exponent below) and a 64-bit mantissa; out_ch returns double_bits and
// was_special (set for an all-ones exponent, which gives a signed infinity).
// Both channels use valid/ready; an item moves when both are high.
// Pipeline: input register, leading-one/exponent stage, normalize stage,
// round stage into the output register. The input, lead, normalize and
// output registers load in that order; throughput is one item per cycle,
// since all stages advance together whenever the output register is free.
// When out_ch.ready is low with a result waiting, the whole pipeline holds
// and in_ch.ready drops; items already inside are kept, none are lost.
// Reset (rst_n low, synchronous) clears all stage valid bits; no item is in
// flight afterwards.
module extended80_to_double_converter_top (
  input  logic       clk,
  input  logic       rst_n,
  e2d_in_if.sink     in_ch,
  e2d_out_if.source  out_ch
);

  logic                 adv;
  logic                 v0_r, v1_r, v2_r, v3_r;
  logic [15:0]          se_r;
  logic [63:0]          m_r;
  e2d_pkg::lead_t       lead, lead_r;
  e2d_pkg::norm_t       nrm, nrm_r;
  logic [63:0]          dbl, dbl_r;
  logic                 spc, spc_r;

  assign adv = !v3_r || out_ch.ready;
  assign in_ch.ready = adv;

  // stage valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0; v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0;
    end else if (adv) begin
      v0_r <= in_ch.valid; v1_r <= v0_r; v2_r <= v1_r; v3_r <= v2_r;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (adv) begin
      se_r   <= in_ch.sign_and_exponent;
      m_r    <= in_ch.mantissa;
      lead_r <= lead;
      nrm_r  <= nrm;
      dbl_r  <= dbl;
      spc_r  <= spc;
    end
  end

  e2d_lead  u_lead  (.se(se_r), .m(m_r), .res(lead));
  e2d_norm  u_norm  (.lead(lead_r), .res(nrm));
  e2d_round u_round (.nrm(nrm_r), .double_bits(dbl), .was_special(spc));

  assign out_ch.valid       = v3_r;
  assign out_ch.double_bits = dbl_r;
  assign out_ch.was_special = spc_r;

`ifndef SYNTHESIS
  a_special_inf: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r && spc_r |-> dbl_r[62:0] == e2d_pkg::DBL_INF_MAG)
    else $error("special item not infinity");
  a_no_nan: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r |-> (dbl_r[62:52] != 11'h7FF) || (dbl_r[51:0] == '0))
    else $error("NaN produced");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r && !adv |=> v2_r && $stable(nrm_r))
    else $error("stage lost while stalled");
`endif

endmodule

### tb/tb_if.sv
// Channel interfaces come from the RTL (e2d_in_if, e2d_out_if); this file only
// holds the shared sequencing helpers for the bench.
package tb_e2d_util_pkg;
  localparam int unsigned MAX_WAIT = 6;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
endpackage

### tb/tb_top.sv
module tb_top;

  typedef struct packed {
    logic [63:0] double_bits;
    logic        was_special;
  } dbl_result_t;

  logic clk;
  logic rst_n;
  int   err_count;
  int   quiet_cycles;
  int   sent_count;
  int   checked_count;
  int   special_count;
  int   zero_count;
  dbl_result_t expected_q[$];

  e2d_in_if  in_ch();
  e2d_out_if out_ch();

  extended80_to_double_converter_top DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // exact conversion of an 80-bit extended value to double bits
  function automatic logic [63:0] to_double_mag(input logic [14:0] e, input logic [63:0] m);
    int          p;
    longint      lsb_exp, x, qexp, s, biased;
    logic [63:0] q, rem, half, bits;
    p = 63;
    while (m[p] == 1'b0) p--;
    lsb_exp = longint'(e) - 16383 - 63;
    x = p + lsb_exp;
    if (x > 1023) return {1'b0, e2d_pkg::DBL_INF_MAG};
    qexp = x - 52;
    if (qexp < -1074) qexp = -1074;
    s = qexp - lsb_exp;
    if (s <= 0) begin
      q = m << (-s);
    end else begin
      if (s >= 65) return 64'd0;
      if (s == 64) begin
        q = 64'd0;
        rem = m;
        half = 64'h8000_0000_0000_0000;
      end else begin
        q = m >> s;
        rem = m & ((64'd1 << s) - 64'd1);
        half = 64'd1 << (s - 1);
      end
      if (rem > half || (rem == half && q[0])) q++;
    end
    if (q < (64'd1 << 52)) return q;
    biased = qexp + 1075;
    bits = (64'(biased - 1) << 52) + q;
    if (bits >= {1'b0, e2d_pkg::DBL_INF_MAG}) return {1'b0, e2d_pkg::DBL_INF_MAG};
    return bits;
  endfunction

  function automatic dbl_result_t predict_double(input logic [15:0] se, input logic [63:0] m);
    dbl_result_t r;
    r.was_special = 1'b0;
    if (se[14:0] == e2d_pkg::EXT_EXP_MAX) begin
      r.double_bits = {1'b0, e2d_pkg::DBL_INF_MAG};
      r.was_special = 1'b1;
    end else if (m == 64'd0) begin
      r.double_bits = 64'd0;
    end else begin
      r.double_bits = to_double_mag(se[14:0], m);
    end
    r.double_bits[63] = se[15];
    return r;
  endfunction

  // send one item after a random gap; valid stays up back to back when gap is 0
  task automatic send_value(input logic [15:0] se, input logic [63:0] m);
    int gap;
    gap = $urandom_range(0, tb_e2d_util_pkg::MAX_WAIT);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.sign_and_exponent <= se;
    in_ch.mantissa <= m;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    expected_q.push_back(predict_double(se, m));
    sent_count++;
    if (se[14:0] == e2d_pkg::EXT_EXP_MAX) special_count++;
    if (m == 64'd0) zero_count++;
  endtask

  task automatic drain_pipeline();
    in_ch.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // fields at their extremes and every special case
  task automatic test_directed();
    send_value(16'h0000, 64'd0);
    send_value(16'h8000, 64'd0);
    send_value(16'h7FFF, 64'd0);
    send_value(16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    send_value(16'h7FFF, 64'hC000_0000_0000_0000);
    send_value(16'h3FFF, 64'h8000_0000_0000_0000);
    send_value(16'hBFFF, 64'h8000_0000_0000_0000);
    send_value(16'h3FFF, 64'hFFFF_FFFF_FFFF_FFFF);
    send_value(16'h3FFF, 64'h8000_0000_0000_0400);
    send_value(16'h3FFF, 64'h8000_0000_0000_0C00);
    send_value(16'h3FFF, 64'h0000_0000_0000_0001);
    send_value(16'h43FE, 64'hFFFF_FFFF_FFFF_FFFF);
    send_value(16'h43FE, 64'hFFFF_FFFF_FFFF_F800);
    send_value(16'h7FFE, 64'h8000_0000_0000_0000);
    send_value(16'h7FFE, 64'd0);
    send_value(16'hC3FF, 64'd0);
    send_value(16'h3C01, 64'h8000_0000_0000_0000);
    send_value(16'h3C00, 64'h8000_0000_0000_0000);
    send_value(16'h3BCD, 64'h8000_0000_0000_0000);
    send_value(16'h3BCC, 64'h8000_0000_0000_0000);
    send_value(16'h3BCC, 64'h8000_0000_0000_0001);
    send_value(16'h3BCB, 64'hFFFF_FFFF_FFFF_FFFF);
    send_value(16'h0000, 64'hFFFF_FFFF_FFFF_FFFF);
    send_value(16'h0001, 64'h0000_0000_0000_0001);
    send_value(16'hC3FF, 64'h0000_0000_0000_0001);
    send_value(16'h3C00, 64'hFFFF_FFFF_FFFF_FFFF);
  endtask

  // random values, weighted toward the double range and its edges
  task automatic test_random(input int n);
    logic [15:0] se;
    logic [63:0] m;
    for (int i = 0; i < n; i++) begin
      m = {$urandom, $urandom};
      se = 16'($urandom);
      case ($urandom_range(0, 9))
        0: se = 16'($urandom);
        1: se = {1'($urandom), 15'($urandom_range(16'h3BB0, 16'h3C10))};
        2: se = {1'($urandom), 15'($urandom_range(16'h43E0, 16'h4410))};
        3: se = {1'($urandom), e2d_pkg::EXT_EXP_MAX};
        4: m = m >> $urandom_range(0, 63);
        5: begin
          se = {1'($urandom), 15'($urandom_range(16'h3C00, 16'h43FF))};
          m[10:0] = 11'h400;
        end
        default: se = {1'($urandom), 15'($urandom_range(16'h3C00, 16'h43FF))};
      endcase
      if ($urandom_range(0, 60) == 0) m = 64'd0;
      send_value(se, m);
    end
  endtask

  // result checker; output side inserts a random stall (possibly none) before each item
  initial begin
    int stall;
    dbl_result_t exp_r;
    out_ch.ready = 1'b0;
    @(posedge clk);
    forever begin
      stall = $urandom_range(0, tb_e2d_util_pkg::MAX_WAIT);
      if ($urandom_range(0, 2) == 0) stall = 0;
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!(rst_n && out_ch.valid)) @(posedge clk);
      if (expected_q.size() == 0) begin
        $error("unexpected result double_bits=%h", out_ch.double_bits);
        err_count++;
      end else begin
        exp_r = expected_q.pop_front();
        checked_count++;
        if (out_ch.double_bits !== exp_r.double_bits) begin
          $error("double_bits expected %h actual %h", exp_r.double_bits, out_ch.double_bits);
          err_count++;
        end
        if (out_ch.was_special !== exp_r.was_special) begin
          $error("was_special expected %b actual %b", exp_r.was_special,
                 out_ch.was_special);
          err_count++;
        end
      end
    end
  end

  // watchdog on cycles with no handshake
  initial begin
    quiet_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= tb_e2d_util_pkg::WATCHDOG_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // sequence of tests
  initial begin
    err_count = 0;
    sent_count = 0;
    checked_count = 0;
    special_count = 0;
    zero_count = 0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.sign_and_exponent = 16'd0;
    in_ch.mantissa = 64'd0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(1450);
    drain_pipeline();
    if (expected_q.size() != 0) begin
      $error("%0d results never arrived", expected_q.size());
      err_count++;
    end
    $display("Converted %0d values, %0d checked (%0d infinity/NaN inputs, %0d zero mantissas).",
             sent_count, checked_count, special_count, zero_count);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
